// ----- design/ars_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ars_pkg
// shared types, widths and constants for the axis rotation step matrix
// ----------------------------------------------------------------------------
package ars_pkg;

  localparam int MU_W  = 33;
  localparam int SQ_W  = 62;
  localparam int LEN_W = 31;

  localparam longint COS5_Q30 = 64'sd1069655912;
  localparam longint SIN5_Q30 = 64'sd93582766;

  typedef logic signed [31:0] word_t;
  typedef logic signed [63:0] prod_t;

  typedef enum logic [2:0] {
    REG_ENABLE  = 3'd0,
    REG_A_X     = 3'd1,
    REG_A_Y     = 3'd2,
    REG_A_Z     = 3'd3,
    REG_B_X     = 3'd4,
    REG_B_Y     = 3'd5,
    REG_B_Z     = 3'd6,
    REG_START   = 3'd7
  } reg_idx_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_NORM  = 8'b0000_0010,
    ST_SUMSQ = 8'b0000_0100,
    ST_SQRT  = 8'b0000_1000,
    ST_DIV   = 8'b0001_0000,
    ST_ENTRY = 8'b0010_0000,
    ST_TRANS = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_t;

endpackage

// ----- design/ars_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ars_mul
// shared signed 32x32 multiplier with registered product
// ----------------------------------------------------------------------------
module ars_mul (
  input  logic           clk,
  input  ars_pkg::word_t op_a,
  input  ars_pkg::word_t op_b,
  output ars_pkg::prod_t prod_r
);
  import ars_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= prod_t'(op_a) * prod_t'(op_b);
  end

endmodule

// ----- design/ars_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ars_sqrt
// bit-pair iterative integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module ars_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ars_pkg::SQ_W-1:0]    x,
  output logic                        done,
  output logic [ars_pkg::LEN_W-1:0]   root
);
  import ars_pkg::*;

  logic [SQ_W-1:0] x_r;
  logic [SQ_W-1:0] res_r;
  logic [SQ_W-1:0] bit_r;
  logic            run_r;
  logic            done_r;
  logic [SQ_W-1:0] trial;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        x_r   <= x;
        res_r <= '0;
        bit_r <= SQ_W'(1) << (SQ_W - 2);
        run_r <= 1'b1;
      end else if (run_r) begin
        if (x_r >= trial) begin
          x_r   <= x_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r[0]) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = res_r[LEN_W-1:0];

endmodule

// ----- design/ars_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ars_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ars_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [ars_pkg::LEN_W+FRAC_BITS-1:0] num,
  input  logic [ars_pkg::LEN_W-1:0]           den,
  output logic                                done,
  output logic [FRAC_BITS:0]                  quot
);
  import ars_pkg::*;

  localparam int Q_W   = FRAC_BITS + 1;
  localparam int CNT_W = $clog2(Q_W + 1);

  logic [LEN_W-1:0] rem_r;
  logic [Q_W-1:0]   low_r;
  logic [Q_W-1:0]   q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;
  logic [LEN_W:0]   t;
  logic             ge;

  assign t  = {rem_r, low_r[Q_W-1]};
  assign ge = (t >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= LEN_W'(num >> Q_W);
        low_r <= num[Q_W-1:0];
        q_r   <= '0;
        cnt_r <= CNT_W'(Q_W);
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= ge ? LEN_W'(t - {1'b0, den}) : LEN_W'(t);
        low_r <= low_r << 1;
        q_r   <= {q_r[Q_W-2:0], ge};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ----- design/axis_rotation_step_matrix.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_rotation_step_matrix
// steps a 5 degree rotation about the line b->a and returns the 4x4 matrix
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready   | frame_tick
//  out_    | output    | out_valid / out_ready | column, four rows, flags
//  cfg_    | input     | apb write/read        | eight registers
//
// a transaction that does not step goes straight to its four column
// transactions; a stepping one runs normalise, sum of squares, square root,
// three divides, nine entries and three translations, with sum of squares,
// entries and translations on one shared multiplier; a zero axis skips them.
// in_ready is high only when idle; reset is synchronous and loads identity.
// ----------------------------------------------------------------------------
module axis_rotation_step_matrix #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_frame_tick,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_column_index,
  output logic signed [31:0] out_entry_row0,
  output logic signed [31:0] out_entry_row1,
  output logic signed [31:0] out_entry_row2,
  output logic signed [31:0] out_entry_row3,
  output logic        out_matrix_updated,
  output logic        out_axis_degenerate,
  output logic        out_last_column,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ars_pkg::*;

  localparam int NW    = FRAC_BITS + 2;
  localparam int NUM_W = LEN_W + FRAC_BITS;
  localparam longint C_Q = (COS5_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
  localparam longint S_Q = (SIN5_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
  localparam word_t  C_W   = word_t'(C_Q);
  localparam word_t  S_W   = word_t'(S_Q);
  localparam word_t  ONE_W = word_t'(64'sd1 <<< FRAC_BITS);
  localparam word_t  OMC_W = word_t'((64'sd1 <<< FRAC_BITS) - C_Q);
  localparam logic [66:0] HALF = 67'd1 << (FRAC_BITS - 1);

  state_t              state_r;
  logic [2:0]          ph_r;
  logic [1:0]          i_r;
  logic [1:0]          j_r;
  logic [1:0]          col_r;
  logic                en_r;
  word_t               a_r [3];
  word_t               b_r [3];
  logic signed [15:0]  start_r;
  logic signed [15:0]  rem_r;
  logic [MU_W-1:0]     mu_r [3];
  logic                neg_r [3];
  logic [SQ_W-1:0]     sum_r;
  logic [LEN_W-1:0]    len_r;
  logic signed [NW-1:0] n_r [3];
  word_t               p_r;
  logic signed [66:0]  acc_r;
  word_t               matrix_r [4][4];
  logic                upd_r;
  logic                degen_r;

  function automatic logic signed [66:0] rnd_f(input logic signed [66:0] v);
    logic [66:0] m;
    m = v[66] ? 67'(-v) : 67'(v);
    m = (m + HALF) >> FRAC_BITS;
    rnd_f = v[66] ? -$signed(m) : $signed(m);
  endfunction

  function automatic word_t sat_f(input logic signed [66:0] v);
    if (v > 67'sd2147483647) sat_f = 32'sh7fff_ffff;
    else if (v < -67'sd2147483648) sat_f = 32'sh8000_0000;
    else sat_f = word_t'(v);
  endfunction

  function automatic word_t sx_f(input logic signed [NW-1:0] v);
    sx_f = {{(32 - NW){v[NW-1]}}, v};
  endfunction

  // axis setup
  logic signed [32:0] d [3];
  logic [MU_W-1:0]    dmag [3];
  logic               axis_zero;
  logic               step;
  logic               in_acc;
  logic               out_acc;
  logic               cfg_wr;
  logic signed [16:0] rem_dec;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d[k]    = 33'(a_r[k]) - 33'(b_r[k]);
      dmag[k] = d[k][32] ? MU_W'(-d[k]) : MU_W'(d[k]);
    end
  end

  assign axis_zero = (dmag[0] == '0) && (dmag[1] == '0) && (dmag[2] == '0);
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign step      = in_frame_tick && en_r && (rem_r != 16'sd0);
  assign rem_dec   = 17'(rem_r) - 17'sd5;
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  // normalise conditions
  logic mu_hi;
  logic mu_top;
  assign mu_hi  = (|mu_r[0][32:30]) || (|mu_r[1][32:30]) || (|mu_r[2][32:30]);
  assign mu_top = mu_r[0][29] || mu_r[1][29] || mu_r[2][29];

  // shared multiplier
  word_t op_a;
  word_t op_b;
  prod_t mul_prod;
  logic signed [NW-1:0] e_val;

  always_comb begin
    case ({i_r, j_r})
      4'b00_01: e_val = -n_r[2];
      4'b00_10: e_val =  n_r[1];
      4'b01_00: e_val =  n_r[2];
      4'b01_10: e_val = -n_r[0];
      4'b10_00: e_val = -n_r[1];
      4'b10_01: e_val =  n_r[0];
      default:  e_val = '0;
    endcase
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_r)
      ST_SUMSQ: begin
        op_a = {2'b00, mu_r[i_r][29:0]};
        op_b = {2'b00, mu_r[i_r][29:0]};
      end
      ST_ENTRY: begin
        if (ph_r == 3'd0) begin
          op_a = sx_f(n_r[i_r]);
          op_b = sx_f(n_r[j_r]);
        end else if (ph_r == 3'd2) begin
          op_a = OMC_W;
          op_b = p_r;
        end else begin
          op_a = S_W;
          op_b = sx_f(e_val);
        end
      end
      ST_TRANS: begin
        op_a = matrix_r[j_r][i_r];
        op_b = b_r[j_r];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  ars_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (mul_prod)
  );

  logic              sqrt_done;
  logic [LEN_W-1:0]  sqrt_root;

  ars_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_SQRT && ph_r == 3'd0),
    .x     (sum_r),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  logic [NUM_W-1:0]  div_num;
  logic              div_done;
  logic [FRAC_BITS:0] div_quot;

  assign div_num = NUM_W'({mu_r[i_r][29:0], {FRAC_BITS{1'b0}}}) + NUM_W'(len_r >> 1);

  ars_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_DIV && ph_r == 3'd0),
    .num   (div_num),
    .den   (len_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  logic signed [66:0] acc_sum;
  logic signed [NW-1:0] q_ext;
  assign acc_sum = acc_r + 67'(mul_prod);
  assign q_ext   = NW'(div_quot);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ph_r    <= '0;
      i_r     <= '0;
      j_r     <= '0;
      col_r   <= '0;
      en_r    <= 1'b0;
      start_r <= '0;
      rem_r   <= '0;
      upd_r   <= 1'b0;
      degen_r <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        a_r[k] <= (k == 0) ? ONE_W : '0;
        b_r[k] <= (k == 0) ? ONE_W : '0;
      end
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          matrix_r[c][r] <= (c == r) ? ONE_W : '0;
        end
      end
    end else begin
      if (cfg_wr) begin
        unique case (reg_idx_t'(cfg_paddr[4:2]))
          REG_ENABLE: en_r   <= cfg_pwdata[0];
          REG_A_X:    a_r[0] <= cfg_pwdata;
          REG_A_Y:    a_r[1] <= cfg_pwdata;
          REG_A_Z:    a_r[2] <= cfg_pwdata;
          REG_B_X:    b_r[0] <= cfg_pwdata;
          REG_B_Y:    b_r[1] <= cfg_pwdata;
          REG_B_Z:    b_r[2] <= cfg_pwdata;
          REG_START: begin
            start_r <= cfg_pwdata[15:0];
            rem_r   <= cfg_pwdata[15:0];
          end
          default: ;
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            upd_r   <= 1'b0;
            degen_r <= 1'b0;
            col_r   <= '0;
            if (step) begin
              rem_r <= (rem_dec < -17'sd32768) ? -16'sd32768 : rem_dec[15:0];
              for (int k = 0; k < 3; k++) begin
                mu_r[k]  <= dmag[k];
                neg_r[k] <= d[k][32];
              end
              if (axis_zero) begin
                degen_r <= 1'b1;
                state_r <= ST_OUT;
              end else begin
                state_r <= ST_NORM;
              end
            end else begin
              state_r <= ST_OUT;
            end
          end
        end
        ST_NORM: begin
          if (mu_hi) begin
            for (int k = 0; k < 3; k++) mu_r[k] <= mu_r[k] >> 1;
          end else if (!mu_top) begin
            for (int k = 0; k < 3; k++) mu_r[k] <= MU_W'(mu_r[k] << 1);
          end else begin
            sum_r   <= '0;
            i_r     <= '0;
            ph_r    <= '0;
            state_r <= ST_SUMSQ;
          end
        end
        ST_SUMSQ: begin
          if (ph_r == 3'd0) begin
            ph_r <= 3'd1;
          end else begin
            sum_r <= sum_r + SQ_W'(mul_prod[59:0]);
            ph_r  <= '0;
            if (i_r == 2'd2) begin
              state_r <= ST_SQRT;
            end else begin
              i_r <= i_r + 2'd1;
            end
          end
        end
        ST_SQRT: begin
          if (ph_r == 3'd0) begin
            ph_r <= 3'd1;
          end else if (sqrt_done) begin
            len_r   <= sqrt_root;
            i_r     <= '0;
            ph_r    <= '0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (ph_r == 3'd0) begin
            ph_r <= 3'd1;
          end else if (div_done) begin
            n_r[i_r] <= neg_r[i_r] ? -q_ext : q_ext;
            ph_r     <= '0;
            if (i_r == 2'd2) begin
              i_r     <= '0;
              j_r     <= '0;
              state_r <= ST_ENTRY;
            end else begin
              i_r <= i_r + 2'd1;
            end
          end
        end
        ST_ENTRY: begin
          case (ph_r)
            3'd0, 3'd2, 3'd4: ph_r <= ph_r + 3'd1;
            3'd1: begin
              p_r  <= word_t'(rnd_f(67'(mul_prod)));
              ph_r <= 3'd2;
            end
            default: begin
              if (ph_r == 3'd3 && i_r != j_r) begin
                acc_r <= 67'(mul_prod);
                ph_r  <= 3'd4;
              end else begin
                if (ph_r == 3'd3) begin
                  matrix_r[j_r][i_r] <= sat_f(67'(C_W) + rnd_f(67'(mul_prod)));
                end else begin
                  matrix_r[j_r][i_r] <= sat_f(rnd_f(acc_sum));
                end
                ph_r <= '0;
                if (j_r == 2'd2) begin
                  j_r <= '0;
                  if (i_r == 2'd2) begin
                    i_r     <= '0;
                    acc_r   <= '0;
                    state_r <= ST_TRANS;
                  end else begin
                    i_r <= i_r + 2'd1;
                  end
                end else begin
                  j_r <= j_r + 2'd1;
                end
              end
            end
          endcase
        end
        ST_TRANS: begin
          if (ph_r == 3'd0) begin
            ph_r <= 3'd1;
          end else begin
            ph_r <= '0;
            if (j_r != 2'd2) begin
              acc_r <= acc_sum;
              j_r   <= j_r + 2'd1;
            end else begin
              matrix_r[3][i_r] <= sat_f(67'(b_r[i_r]) - rnd_f(acc_sum));
              matrix_r[i_r][3] <= '0;
              acc_r <= '0;
              j_r   <= '0;
              if (i_r == 2'd2) begin
                matrix_r[3][3] <= ONE_W;
                upd_r   <= 1'b1;
                col_r   <= '0;
                state_r <= ST_OUT;
              end else begin
                i_r <= i_r + 2'd1;
              end
            end
          end
        end
        ST_OUT: begin
          if (out_acc) begin
            if (col_r == 2'd3) begin
              state_r <= ST_IDLE;
            end else begin
              col_r <= col_r + 2'd1;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // result channel
  assign out_column_index    = col_r;
  assign out_entry_row0      = matrix_r[col_r][0];
  assign out_entry_row1      = matrix_r[col_r][1];
  assign out_entry_row2      = matrix_r[col_r][2];
  assign out_entry_row3      = matrix_r[col_r][3];
  assign out_matrix_updated  = upd_r;
  assign out_axis_degenerate = degen_r;
  assign out_last_column     = (col_r == 2'd3);

  // register readback
  always_comb begin
    unique case (reg_idx_t'(cfg_paddr[4:2]))
      REG_ENABLE: cfg_prdata = {31'd0, en_r};
      REG_A_X:    cfg_prdata = a_r[0];
      REG_A_Y:    cfg_prdata = a_r[1];
      REG_A_Z:    cfg_prdata = a_r[2];
      REG_B_X:    cfg_prdata = b_r[0];
      REG_B_Y:    cfg_prdata = b_r[1];
      REG_B_Z:    cfg_prdata = b_r[2];
      REG_START:  cfg_prdata = {16'd0, start_r};
      default:    cfg_prdata = '0;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and result channels active together");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_matrix_updated && out_axis_degenerate))
    else $error("updated and degenerate both set");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_column) |=> in_ready)
    else $error("not idle after last column");

  a_col_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (out_column_index == 2'd0))
    else $error("column count not restarted");

endmodule
